// File: rtl/tcp_pkg.sv
// ============================================================================
// tcp_pkg: shared types, constants and functions of the tracker cell packer
// Holds the period table, effect command codes, code-form prefixes and the
// period-to-note lookup.
// ============================================================================
package tcp_pkg;

    // Field widths
    localparam int PERIOD_W = 12;
    localparam int INSTR_W  = 5;
    localparam int CMD_W    = 4;
    localparam int PARAM_W  = 8;
    localparam int NOTE_W   = 6;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 2;
    localparam int USAGE_W  = 32;

    localparam int NOTE_COUNT = 36;

    typedef logic [PERIOD_W-1:0] period_t;
    typedef logic [NOTE_W-1:0]   note_t;
    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [PARAM_W-1:0]  param_t;
    typedef logic [USAGE_W-1:0]  usage_t;

    // Three-octave period table, note index is position + 1
    localparam period_t NOTE_PERIODS [NOTE_COUNT] = '{
        12'd856, 12'd808, 12'd762, 12'd720, 12'd678, 12'd640,
        12'd604, 12'd570, 12'd538, 12'd508, 12'd480, 12'd453,
        12'd428, 12'd404, 12'd381, 12'd360, 12'd339, 12'd320,
        12'd302, 12'd285, 12'd269, 12'd254, 12'd240, 12'd226,
        12'd214, 12'd202, 12'd190, 12'd180, 12'd170, 12'd160,
        12'd151, 12'd143, 12'd135, 12'd127, 12'd120, 12'd113
    };

    // Effect commands
    localparam cmd_t CMD_ARPEGGIO   = 4'h0;
    localparam cmd_t CMD_SLIDE_UP   = 4'h1;
    localparam cmd_t CMD_SLIDE_DOWN = 4'h2;
    localparam cmd_t CMD_PAN        = 4'h8;
    localparam cmd_t CMD_VOLUME     = 4'hC;
    localparam cmd_t CMD_EXTENDED   = 4'hE;

    // Extended commands (high nibble of the parameter)
    localparam cmd_t EXT_FILTER        = 4'h0;
    localparam cmd_t EXT_FINE_UP       = 4'h1;
    localparam cmd_t EXT_FINE_DOWN     = 4'h2;
    localparam cmd_t EXT_RETRIGGER     = 4'h9;
    localparam cmd_t EXT_FINE_VOL_UP   = 4'hA;
    localparam cmd_t EXT_FINE_VOL_DOWN = 4'hB;
    localparam cmd_t EXT_NOTE_CUT      = 4'hC;
    localparam cmd_t EXT_NOTE_DELAY    = 4'hD;
    localparam cmd_t EXT_PATTERN_DELAY = 4'hE;

    localparam param_t MAX_VOLUME = 8'd64;

    // Code-form prefixes
    localparam logic [BYTE_W-1:0] CODE_EMPTY      = 8'h7F;
    localparam logic [BYTE_W-1:0] CODE_NOTE_INSTR = 8'h70;
    localparam logic [BYTE_W-1:0] CODE_CMD_ONLY   = 8'h60;

    // Code lengths
    localparam logic [LEN_W-1:0] LEN_ONE   = 2'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 2'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 2'd3;

    // Match a period against all table entries in parallel; 0 when none match
    function automatic note_t note_of_period(input period_t p);
        note_t n;
        n = '0;
        for (int k = 0; k < NOTE_COUNT; k++) begin
            if (NOTE_PERIODS[k] == p) begin
                n = n | note_t'(k + 1);
            end
        end
        return n;
    endfunction

endpackage

// File: rtl/tcp_if.sv
// ============================================================================
// tcp_cell_if / tcp_code_if: valid-ready channels of the cell packer
// One channel carries pattern cells in, the other packed cell codes out.
// ============================================================================
interface tcp_cell_if;
    logic                              valid;
    logic                              ready;
    logic                              start_new;
    logic [tcp_pkg::PERIOD_W-1:0]      period;
    logic [tcp_pkg::INSTR_W-1:0]       instrument;
    logic [tcp_pkg::CMD_W-1:0]         effect_cmd;
    logic [tcp_pkg::PARAM_W-1:0]       effect_param;

    modport source (
        output valid, start_new, period, instrument, effect_cmd, effect_param,
        input  ready
    );
    modport sink (
        input  valid, start_new, period, instrument, effect_cmd, effect_param,
        output ready
    );
endinterface

interface tcp_code_if;
    logic                              valid;
    logic                              ready;
    logic [tcp_pkg::BYTE_W-1:0]        code_byte0;
    logic [tcp_pkg::BYTE_W-1:0]        code_byte1;
    logic [tcp_pkg::BYTE_W-1:0]        code_byte2;
    logic [tcp_pkg::LEN_W-1:0]         code_length;
    logic [tcp_pkg::USAGE_W-1:0]       usage_mask;

    modport source (
        output valid, code_byte0, code_byte1, code_byte2, code_length, usage_mask,
        input  ready
    );
    modport sink (
        input  valid, code_byte0, code_byte1, code_byte2, code_length, usage_mask,
        output ready
    );
endinterface

// File: rtl/tracker_cell_packer_core.sv
// ============================================================================
// tracker_cell_packer_core: packs tracker pattern cells into 1..3 byte codes
// Two-stage pipeline: input register, then note lookup, effect rewrite,
// packing and usage accumulation into the result register.
// ============================================================================
// Takes one pattern cell per cycle, unless stalled, on the pattern channel
// and returns one packed code per cell on the code channel, in order, from
// the result register, where it can be taken; throughput is one item per
// cycle when not stalled, set by the single combinational pass between the
// input register and the result register. The usage mask is a running OR
// of effect bits that start_new clears before its own cell; it advances as
// each item enters the result register. Backpressure from the code channel
// stalls both stages.
module tracker_cell_packer_core (
    input  logic        clk,
    input  logic        rst_n,
    tcp_cell_if.sink    pattern,
    tcp_code_if.source  code
);

    // Input stage
    logic                           s1_valid_reg;
    logic                           s1_start_reg;
    tcp_pkg::period_t               s1_period_reg;
    logic [tcp_pkg::INSTR_W-1:0]    s1_instr_reg;
    tcp_pkg::cmd_t                  s1_cmd_reg;
    tcp_pkg::param_t                s1_param_reg;

    // Result stage
    logic                           out_valid_reg;
    logic [tcp_pkg::BYTE_W-1:0]     out_b0_reg;
    logic [tcp_pkg::BYTE_W-1:0]     out_b1_reg;
    logic [tcp_pkg::BYTE_W-1:0]     out_b2_reg;
    logic [tcp_pkg::LEN_W-1:0]      out_len_reg;
    tcp_pkg::usage_t                out_usage_reg;

    tcp_pkg::usage_t                acc_reg;
    tcp_pkg::usage_t                acc_next;

    logic                           advance;
    logic                           s1_move;

    tcp_pkg::note_t                 note;
    tcp_pkg::cmd_t                  cmd_fx;
    tcp_pkg::param_t                param_fx;
    logic                           has_fx;
    tcp_pkg::cmd_t                  ext;
    tcp_pkg::cmd_t                  low;
    tcp_pkg::cmd_t                  cmd_fin;
    tcp_pkg::param_t                param_fin;
    logic [tcp_pkg::BYTE_W-1:0]     b0_next;
    logic [tcp_pkg::BYTE_W-1:0]     b1_next;
    logic [tcp_pkg::BYTE_W-1:0]     b2_next;
    logic [tcp_pkg::LEN_W-1:0]      len_next;
    logic                           has_note;
    logic                           has_instr;

    // Handshake: result stage frees when empty or taken
    assign advance       = !out_valid_reg || code.ready;
    assign s1_move       = s1_valid_reg && advance;
    assign pattern.ready = !s1_valid_reg || advance;

    // Capture input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pattern.ready)
        begin
            s1_valid_reg <= pattern.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pattern.valid && pattern.ready)
        begin
            s1_start_reg  <= pattern.start_new;
            s1_period_reg <= pattern.period;
            s1_instr_reg  <= pattern.instrument;
            s1_cmd_reg    <= pattern.effect_cmd;
            s1_param_reg  <= pattern.effect_param;
        end
    end

    // Look up note index
    assign note = tcp_pkg::note_of_period(s1_period_reg);
    assign ext  = s1_param_reg[7:4];
    assign low  = s1_param_reg[3:0];

    // Rewrite effect
    always_comb
    begin
        cmd_fx   = s1_cmd_reg;
        param_fx = s1_param_reg;
        has_fx   = (s1_cmd_reg != '0) || (s1_param_reg != '0);
        case (s1_cmd_reg)
            tcp_pkg::CMD_ARPEGGIO:
            begin
                if (s1_param_reg != '0)
                begin
                    cmd_fx = tcp_pkg::CMD_PAN;
                end
            end
            tcp_pkg::CMD_SLIDE_UP,
            tcp_pkg::CMD_SLIDE_DOWN:
            begin
                has_fx = s1_param_reg != '0;
            end
            tcp_pkg::CMD_VOLUME:
            begin
                if (s1_param_reg > tcp_pkg::MAX_VOLUME)
                begin
                    param_fx = tcp_pkg::MAX_VOLUME;
                end
            end
            tcp_pkg::CMD_PAN:
            begin
                cmd_fx   = tcp_pkg::CMD_EXTENDED;
                param_fx = {tcp_pkg::CMD_PAN, low};
            end
            tcp_pkg::CMD_EXTENDED:
            begin
                case (ext)
                    tcp_pkg::EXT_FILTER:
                    begin
                        param_fx = {6'd0, low[0], 1'b0};
                    end
                    tcp_pkg::EXT_NOTE_CUT:
                    begin
                        if (low == '0)
                        begin
                            cmd_fx   = tcp_pkg::CMD_VOLUME;
                            param_fx = '0;
                        end
                    end
                    tcp_pkg::EXT_FINE_UP,
                    tcp_pkg::EXT_FINE_DOWN,
                    tcp_pkg::EXT_RETRIGGER,
                    tcp_pkg::EXT_FINE_VOL_UP,
                    tcp_pkg::EXT_FINE_VOL_DOWN,
                    tcp_pkg::EXT_NOTE_DELAY,
                    tcp_pkg::EXT_PATTERN_DELAY:
                    begin
                        has_fx = low != '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // Drop empty effects
    assign cmd_fin   = has_fx ? cmd_fx   : tcp_pkg::CMD_ARPEGGIO;
    assign param_fin = has_fx ? param_fx : '0;

    // Accumulate effect usage
    always_comb
    begin
        acc_next = s1_start_reg ? '0 : acc_reg;
        if (cmd_fin == tcp_pkg::CMD_EXTENDED)
        begin
            acc_next[{1'b1, param_fin[7:4]}] = 1'b1;
        end
        else
        begin
            acc_next[{1'b0, cmd_fin}] = 1'b1;
        end
    end

    // Pack the cell code
    assign has_note  = note != '0;
    assign has_instr = s1_instr_reg != '0;

    always_comb
    begin
        if (!has_note && !has_instr && !has_fx)
        begin
            b0_next  = tcp_pkg::CODE_EMPTY;
            b1_next  = '0;
            b2_next  = '0;
            len_next = tcp_pkg::LEN_ONE;
        end
        else if (has_note && has_instr && !has_fx)
        begin
            b0_next  = tcp_pkg::CODE_NOTE_INSTR | {5'd0, note[5:3]};
            b1_next  = {note[2:0], s1_instr_reg};
            b2_next  = '0;
            len_next = tcp_pkg::LEN_TWO;
        end
        else if (!has_note && !has_instr && has_fx)
        begin
            b0_next  = tcp_pkg::CODE_CMD_ONLY | {4'd0, cmd_fin};
            b1_next  = param_fin;
            b2_next  = '0;
            len_next = tcp_pkg::LEN_TWO;
        end
        else
        begin
            b0_next  = {1'b0, note, s1_instr_reg[4]};
            b1_next  = {s1_instr_reg[3:0], cmd_fin};
            b2_next  = param_fin;
            len_next = tcp_pkg::LEN_THREE;
        end
    end

    // Hold result and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_move)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_b0_reg    <= b0_next;
            out_b1_reg    <= b1_next;
            out_b2_reg    <= b2_next;
            out_len_reg   <= len_next;
            out_usage_reg <= acc_next;
        end
    end

    assign code.valid       = out_valid_reg;
    assign code.code_byte0  = out_b0_reg;
    assign code.code_byte1  = out_b1_reg;
    assign code.code_byte2  = out_b2_reg;
    assign code.code_length = out_len_reg;
    assign code.usage_mask  = out_usage_reg;

    // Checks
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_len_reg != '0)
        else $error("code length zero");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_len_reg == tcp_pkg::LEN_ONE) |->
        (out_b0_reg == tcp_pkg::CODE_EMPTY && out_b1_reg == '0 && out_b2_reg == '0))
        else $error("one-byte code is not the empty form");

    a_byte2_unused: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_len_reg != tcp_pkg::LEN_THREE) |-> out_b2_reg == '0)
        else $error("unused third byte not zero");

    a_usage_tracks_acc: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_usage_reg == acc_reg)
        else $error("result usage mask differs from accumulator");

    a_acc_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && !s1_start_reg) |=> (acc_reg & $past(acc_reg)) == $past(acc_reg))
        else $error("usage accumulator lost a bit without start");

endmodule

// File: tb/tracker_cell_packer_core_test.sv
// ============================================================================
// tracker_cell_packer_core_test: self-checking bench of the cell packer
// Drives pattern cells through the cell channel and checks every packed code
// against its typed-in code or a cycle-free model of the period lookup,
// effect rewrite, packing and usage accumulation. A short table of directed
// cells comes first, then random cells under several idle and stall mixes,
// with one long output hold-off to fill the pipeline.
// ============================================================================
module tracker_cell_packer_core_test;

    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 240;
    localparam int PRESSURE_ITEMS = 40;
    localparam int DIRECTED_COUNT = 25;

    // Commands the package leaves unnamed
    localparam tcp_pkg::cmd_t CMD_SPEED = 4'hF;
    localparam tcp_pkg::cmd_t EXT_PAN   = 4'h8;

    typedef struct packed {
        logic                          start_new;
        tcp_pkg::period_t              period;
        logic [tcp_pkg::INSTR_W-1:0]   instrument;
        tcp_pkg::cmd_t                 effect_cmd;
        tcp_pkg::param_t               effect_param;
    } cell_t;

    typedef struct packed {
        logic [tcp_pkg::BYTE_W-1:0]    code_byte0;
        logic [tcp_pkg::BYTE_W-1:0]    code_byte1;
        logic [tcp_pkg::BYTE_W-1:0]    code_byte2;
        logic [tcp_pkg::LEN_W-1:0]     code_length;
        tcp_pkg::usage_t               usage_mask;
    } code_t;

    // One cell to send, with its code typed in when known is set
    typedef struct packed {
        cell_t                pattern;
        logic                 known;
        code_t                code;
    } cell_row_t;

    localparam code_t NO_CODE = '0;

    logic clk = 1'b0;
    logic rst_n;

    tcp_cell_if cell_ch ();
    tcp_code_if code_ch ();

    tracker_cell_packer_core dut (clk, rst_n, cell_ch, code_ch);

    cell_row_t       cells_to_send [$];
    code_t           expected_codes [$];
    tcp_pkg::usage_t usage_acc;
    int              src_idle_pct;
    int              sink_stall_pct;
    int              hold_requests;
    int              mismatch_count;

    cell_row_t directed_rows [DIRECTED_COUNT] = '{
        // empty cell right after reset
        {1'b0, 12'd0,    5'd0,  tcp_pkg::CMD_ARPEGGIO,   8'h00, 1'b1,
         tcp_pkg::CODE_EMPTY, 8'h00, 8'h00, tcp_pkg::LEN_ONE, 32'h0000_0001},
        // first and last note with instrument
        {1'b1, 12'd856,  5'd1,  tcp_pkg::CMD_ARPEGGIO,   8'h00, 1'b1,
         8'h70, 8'h21, 8'h00, tcp_pkg::LEN_TWO, 32'h0000_0001},
        {1'b1, 12'd113,  5'd31, tcp_pkg::CMD_ARPEGGIO,   8'h00, 1'b1,
         8'h74, 8'h9F, 8'h00, tcp_pkg::LEN_TWO, 32'h0000_0001},
        // unmatched period acts as no note
        {1'b1, 12'd4095, 5'd0,  tcp_pkg::CMD_ARPEGGIO,   8'h00, 1'b1,
         tcp_pkg::CODE_EMPTY, 8'h00, 8'h00, tcp_pkg::LEN_ONE, 32'h0000_0001},
        // arpeggio turns into command 8
        {1'b1, 12'd0,    5'd0,  tcp_pkg::CMD_ARPEGGIO,   8'h37, 1'b1,
         8'h68, 8'h37, 8'h00, tcp_pkg::LEN_TWO, 32'h0000_0100},
        // zero slide is dropped, nonzero slide kept
        {1'b1, 12'd0,    5'd0,  tcp_pkg::CMD_SLIDE_UP,   8'h00, 1'b1,
         tcp_pkg::CODE_EMPTY, 8'h00, 8'h00, tcp_pkg::LEN_ONE, 32'h0000_0001},
        {1'b1, 12'd0,    5'd0,  tcp_pkg::CMD_SLIDE_DOWN, 8'hFF, 1'b1,
         8'h62, 8'hFF, 8'h00, tcp_pkg::LEN_TWO, 32'h0000_0004},
        // volume saturates
        {1'b1, 12'd0,    5'd0,  tcp_pkg::CMD_VOLUME,     8'hFF, 1'b1,
         8'h6C, 8'h40, 8'h00, tcp_pkg::LEN_TWO, 32'h0000_1000},
        {1'b0, 12'd0,    5'd0,  tcp_pkg::CMD_VOLUME,     8'd64, 1'b0, NO_CODE},
        // command 8 becomes extended 8
        {1'b1, 12'd0,    5'd0,  tcp_pkg::CMD_PAN,        8'hA5, 1'b1,
         8'h6E, 8'h85, 8'h00, tcp_pkg::LEN_TWO, 32'h0100_0000},
        // filter keeps bit 0 only, shifted up
        {1'b1, 12'd0,    5'd0,  tcp_pkg::CMD_EXTENDED,
         {tcp_pkg::EXT_FILTER, 4'hF}, 1'b1,
         8'h6E, 8'h02, 8'h00, tcp_pkg::LEN_TWO, 32'h0001_0000},
        // note cut at tick zero becomes volume zero
        {1'b1, 12'd0,    5'd0,  tcp_pkg::CMD_EXTENDED,
         {tcp_pkg::EXT_NOTE_CUT, 4'h0}, 1'b1,
         8'h6C, 8'h00, 8'h00, tcp_pkg::LEN_TWO, 32'h0000_1000},
        {1'b0, 12'd0,    5'd0,  tcp_pkg::CMD_EXTENDED,
         {tcp_pkg::EXT_NOTE_CUT, 4'h5}, 1'b0, NO_CODE},
        // extended commands with a zero low nibble are dropped
        {1'b1, 12'd0,    5'd0,  tcp_pkg::CMD_EXTENDED,
         {tcp_pkg::EXT_FINE_UP, 4'h0}, 1'b1,
         tcp_pkg::CODE_EMPTY, 8'h00, 8'h00, tcp_pkg::LEN_ONE, 32'h0000_0001},
        {1'b0, 12'd640,  5'd3,  tcp_pkg::CMD_EXTENDED,
         {tcp_pkg::EXT_FINE_DOWN, 4'h0}, 1'b0, NO_CODE},
        {1'b0, 12'd0,    5'd0,  tcp_pkg::CMD_EXTENDED,
         {tcp_pkg::EXT_RETRIGGER, 4'h0}, 1'b0, NO_CODE},
        {1'b0, 12'd0,    5'd7,  tcp_pkg::CMD_EXTENDED,
         {tcp_pkg::EXT_FINE_VOL_UP, 4'h0}, 1'b0, NO_CODE},
        {1'b0, 12'd0,    5'd0,  tcp_pkg::CMD_EXTENDED,
         {tcp_pkg::EXT_FINE_VOL_DOWN, 4'h0}, 1'b0, NO_CODE},
        {1'b0, 12'd302,  5'd0,  tcp_pkg::CMD_EXTENDED,
         {tcp_pkg::EXT_NOTE_DELAY, 4'h0}, 1'b0, NO_CODE},
        {1'b0, 12'd0,    5'd0,  tcp_pkg::CMD_EXTENDED,
         {tcp_pkg::EXT_PATTERN_DELAY, 4'h0}, 1'b0, NO_CODE},
        {1'b0, 12'd0,    5'd0,  tcp_pkg::CMD_EXTENDED,
         {tcp_pkg::EXT_PATTERN_DELAY, 4'hF}, 1'b0, NO_CODE},
        // note alone and instrument alone take the full form
        {1'b1, 12'd428,  5'd0,  tcp_pkg::CMD_ARPEGGIO,   8'h00, 1'b1,
         8'h1A, 8'h00, 8'h00, tcp_pkg::LEN_THREE, 32'h0000_0001},
        {1'b1, 12'd0,    5'd17, tcp_pkg::CMD_ARPEGGIO,   8'h00, 1'b1,
         8'h01, 8'h10, 8'h00, tcp_pkg::LEN_THREE, 32'h0000_0001},
        {1'b0, 12'd0,    5'd5,  CMD_SPEED,               8'h7D, 1'b0, NO_CODE},
        // every field at its top
        {1'b1, 12'd113,  5'd31, CMD_SPEED,               8'hFF, 1'b1,
         8'h49, 8'hFF, 8'hFF, tcp_pkg::LEN_THREE, 32'h0000_8000}
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predict the code of one cell and advance the usage mask
    function automatic code_t pack_cell(input cell_t c);
        tcp_pkg::note_t  note;
        tcp_pkg::cmd_t   cmd;
        tcp_pkg::param_t param;
        logic            has;
        code_t           r;
        note = '0;
        for (int k = 0; k < tcp_pkg::NOTE_COUNT; k++)
        begin
            if (tcp_pkg::NOTE_PERIODS[k] == c.period)
                note = tcp_pkg::note_t'(k + 1);
        end
        cmd   = c.effect_cmd;
        param = c.effect_param;
        has   = (cmd != 0) || (param != 0);

        // rewrite the effect
        case (cmd)
            tcp_pkg::CMD_ARPEGGIO:
                if (param != 0)
                    cmd = tcp_pkg::CMD_PAN;
            tcp_pkg::CMD_SLIDE_UP, tcp_pkg::CMD_SLIDE_DOWN:
                has = (param != 0);
            tcp_pkg::CMD_VOLUME:
                if (param > tcp_pkg::MAX_VOLUME)
                    param = tcp_pkg::MAX_VOLUME;
            tcp_pkg::CMD_PAN:
            begin
                cmd   = tcp_pkg::CMD_EXTENDED;
                param = {EXT_PAN, param[3:0]};
            end
            tcp_pkg::CMD_EXTENDED:
                case (param[7:4])
                    tcp_pkg::EXT_FILTER:
                        param = {6'd0, param[0], 1'b0};
                    tcp_pkg::EXT_NOTE_CUT:
                        if (param[3:0] == 0)
                        begin
                            cmd   = tcp_pkg::CMD_VOLUME;
                            param = '0;
                        end
                    tcp_pkg::EXT_FINE_UP, tcp_pkg::EXT_FINE_DOWN,
                    tcp_pkg::EXT_RETRIGGER, tcp_pkg::EXT_FINE_VOL_UP,
                    tcp_pkg::EXT_FINE_VOL_DOWN, tcp_pkg::EXT_NOTE_DELAY,
                    tcp_pkg::EXT_PATTERN_DELAY:
                        has = (param[3:0] != 0);
                    default: ;
                endcase
            default: ;
        endcase
        if (!has)
        begin
            cmd   = tcp_pkg::CMD_ARPEGGIO;
            param = '0;
        end

        // accumulate usage
        if (c.start_new)
            usage_acc = '0;
        if (cmd == tcp_pkg::CMD_EXTENDED)
            usage_acc[16 + param[7:4]] = 1'b1;
        else
            usage_acc[cmd] = 1'b1;

        // pack
        r = '0;
        if (note == 0 && c.instrument == 0 && !has)
        begin
            r.code_byte0  = tcp_pkg::CODE_EMPTY;
            r.code_length = tcp_pkg::LEN_ONE;
        end
        else if (note != 0 && c.instrument != 0 && !has)
        begin
            r.code_byte0  = tcp_pkg::CODE_NOTE_INSTR | {5'd0, note[5:3]};
            r.code_byte1  = {note[2:0], c.instrument};
            r.code_length = tcp_pkg::LEN_TWO;
        end
        else if (note == 0 && c.instrument == 0 && has)
        begin
            r.code_byte0  = tcp_pkg::CODE_CMD_ONLY | {4'd0, cmd};
            r.code_byte1  = param;
            r.code_length = tcp_pkg::LEN_TWO;
        end
        else
        begin
            r.code_byte0  = {1'b0, note, c.instrument[4]};
            r.code_byte1  = {c.instrument[3:0], cmd};
            r.code_byte2  = param;
            r.code_length = tcp_pkg::LEN_THREE;
        end
        r.usage_mask = usage_acc;
        return r;
    endfunction

    // Random cell, weighted toward table periods and the rewritten effects
    function automatic cell_t random_cell();
        cell_t c;
        int    pick;
        c.start_new = ($urandom_range(19) == 0);
        pick = $urandom_range(99);
        if (pick < 55)
            c.period = tcp_pkg::NOTE_PERIODS[$urandom_range(tcp_pkg::NOTE_COUNT - 1)];
        else if (pick < 70)
            c.period = '0;
        else
            c.period = tcp_pkg::period_t'($urandom_range(4095));
        c.instrument = ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom_range(31));
        pick = $urandom_range(9);
        if (pick < 3)
            c.effect_cmd = tcp_pkg::CMD_EXTENDED;
        else if (pick < 4)
            c.effect_cmd = tcp_pkg::CMD_ARPEGGIO;
        else
            c.effect_cmd = tcp_pkg::cmd_t'($urandom_range(15));
        case ($urandom_range(4))
            0:       c.effect_param = '0;
            1:       c.effect_param = {4'($urandom_range(15)), 4'h0};
            2:       c.effect_param = tcp_pkg::param_t'($urandom_range(70, 60));
            default: c.effect_param = tcp_pkg::param_t'($urandom_range(255));
        endcase
        return c;
    endfunction

    // Hold until every queued cell is in and every code is out
    task automatic wait_drained();
        while (cells_to_send.size() != 0 || cell_ch.valid || expected_codes.size() != 0)
            @(posedge clk);
    endtask

    // Cell driver: record each accepted item, then offer the next one
    initial
    begin
        cell_row_t row;
        cell_ch.valid        = 1'b0;
        cell_ch.start_new    = 1'b0;
        cell_ch.period       = '0;
        cell_ch.instrument   = '0;
        cell_ch.effect_cmd   = '0;
        cell_ch.effect_param = '0;
        forever
        begin
            @(posedge clk);
            if (cell_ch.valid && cell_ch.ready)
            begin
                row = cells_to_send.pop_front();
                if (row.known)
                begin
                    void'(pack_cell(row.pattern));
                    expected_codes.push_back(row.code);
                end
                else
                    expected_codes.push_back(pack_cell(row.pattern));
            end
            if (!cell_ch.valid || cell_ch.ready)
            begin
                if (rst_n && cells_to_send.size() != 0 &&
                    $urandom_range(99) >= src_idle_pct)
                begin
                    cell_ch.valid        <= 1'b1;
                    cell_ch.start_new    <= cells_to_send[0].pattern.start_new;
                    cell_ch.period       <= cells_to_send[0].pattern.period;
                    cell_ch.instrument   <= cells_to_send[0].pattern.instrument;
                    cell_ch.effect_cmd   <= cells_to_send[0].pattern.effect_cmd;
                    cell_ch.effect_param <= cells_to_send[0].pattern.effect_param;
                end
                else
                    cell_ch.valid <= 1'b0;
            end
        end
    end

    // Code receiver: check each accepted item, then pick ready
    initial
    begin
        code_t got;
        code_t want;
        int    hold_left;
        int    hold_seen;
        code_ch.ready = 1'b0;
        hold_left     = 0;
        hold_seen     = 0;
        forever
        begin
            @(posedge clk);
            if (code_ch.valid && code_ch.ready)
            begin
                got = {code_ch.code_byte0, code_ch.code_byte1, code_ch.code_byte2,
                       code_ch.code_length, code_ch.usage_mask};
                if (expected_codes.size() == 0)
                begin
                    $display("%0t: code with none expected, got %h", $time, got);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_codes.pop_front();
                    if (got.code_byte0 !== want.code_byte0)
                    begin
                        $display("%0t: code_byte0 expected %h got %h",
                                 $time, want.code_byte0, got.code_byte0);
                        mismatch_count++;
                    end
                    if (got.code_byte1 !== want.code_byte1)
                    begin
                        $display("%0t: code_byte1 expected %h got %h",
                                 $time, want.code_byte1, got.code_byte1);
                        mismatch_count++;
                    end
                    if (got.code_byte2 !== want.code_byte2)
                    begin
                        $display("%0t: code_byte2 expected %h got %h",
                                 $time, want.code_byte2, got.code_byte2);
                        mismatch_count++;
                    end
                    if (got.code_length !== want.code_length)
                    begin
                        $display("%0t: code_length expected %0d got %0d",
                                 $time, want.code_length, got.code_length);
                        mismatch_count++;
                    end
                    if (got.usage_mask !== want.usage_mask)
                    begin
                        $display("%0t: usage_mask expected %h got %h",
                                 $time, want.usage_mask, got.usage_mask);
                        mismatch_count++;
                    end
                end
            end
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (!rst_n)
                code_ch.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                code_ch.ready <= 1'b0;
            end
            else
                code_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cell_ch.valid && cell_ch.ready) || (code_ch.valid && code_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Sequence: reset, directed table, long hold-off, random phases
    initial
    begin
        cell_row_t row;
        rst_n          = 1'b0;
        usage_acc      = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_requests  = 0;
        mismatch_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++)
            cells_to_send.push_back(directed_rows[i]);
        wait_drained();

        // fill the pipeline against a stalled output
        hold_requests++;
        for (int i = 0; i < PRESSURE_ITEMS; i++)
        begin
            row         = '0;
            row.pattern = random_cell();
            cells_to_send.push_back(row);
        end
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 52; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 52; end
                default: begin src_idle_pct = 7;  sink_stall_pct = 7;  end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                row         = '0;
                row.pattern = random_cell();
                cells_to_send.push_back(row);
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
